[hw/rtl/dsl_pkg.sv]
// Shared types and codes for the descending sorted list block.
// Used by the top level, the step unit and the port checker; depends on nothing.
package dsl_pkg;

    localparam int KEY_W = 32;

    localparam logic OP_INS = 1'b0;
    localparam logic OP_DEL = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef logic signed [KEY_W-1:0] t_key;

    // Decision of one scan step over a stored word
    typedef struct packed {
        logic we;     // write this step
        logic back;   // write one slot toward the head (delete shift)
        logic hit;    // insert point or delete match found at this word
        t_key wdata;  // word to write
    } t_step;

endpackage

[hw/rtl/dsl_step.sv]
// Shared compare unit: decides the write of one scan step of an insert or delete.
// Depends on dsl_pkg.
module dsl_step (
    input  logic          i_op,
    input  dsl_pkg::t_key i_key,
    input  dsl_pkg::t_key i_rdata,
    input  dsl_pkg::t_key i_carry,
    input  logic          i_flag,
    output dsl_pkg::t_step o_step
);
    import dsl_pkg::*;

    logic le;

    assign le = (i_rdata <= i_key);

    always_comb begin
        o_step = '{we: 1'b0, back: 1'b0, hit: 1'b0, wdata: i_rdata};
        if (i_op == OP_INS) begin
            // place the key ahead of the first word not above it, then ripple
            if (!i_flag && le) begin
                o_step.we    = 1'b1;
                o_step.hit   = 1'b1;
                o_step.wdata = i_key;
            end else if (i_flag) begin
                o_step.we    = 1'b1;
                o_step.wdata = i_carry;
            end
        end else begin
            // after the match, move each word one slot toward the head
            if (i_flag) begin
                o_step.we   = 1'b1;
                o_step.back = 1'b1;
            end else if (i_rdata == i_key) begin
                o_step.hit = 1'b1;
            end
        end
    end

endmodule

[hw/rtl/descending_sorted_list.sv]
// Top level of the descending sorted list: sequencer, key store and result register.
// Depends on dsl_pkg and dsl_step.
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  -------------------------------------------
//  command   in         i_valid / o_stall   i_op, i_key
//  result    out        o_valid / i_stall   o_status, o_entry_valid, o_entry_key,
//                                           o_position, o_list_count, o_last
//
// Steps: accept, scan the words (an insert also visits the tail slot), reopen the store,
// then emit one result word per stored word; the scan goes through the single store read
// port and the one compare unit. A full or empty reject gives a lone status word, as do
// a delete miss and a delete of the only word, each after its scan.
// Reset clears state, word count and result valid; the store is left as is.
// A result stall holds the result word and pauses the emit; o_stall stays high while busy.
module descending_sorted_list #(
    parameter int DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // command channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_op,
    input  logic signed [31:0]     i_key,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic                   o_entry_valid,
    output logic signed [31:0]     o_entry_key,
    output logic [3:0]             o_position,
    output logic [4:0]             o_list_count,
    output logic                   o_last
);
    import dsl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_DEL,
        S_PREP,
        S_EMIT,
        S_SOLO
    } t_state;

    t_state        r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_oidx;
    logic          r_op;
    t_key          r_key;
    t_key          r_carry;
    logic          r_flag;
    logic [1:0]    r_solo_status;

    // key store
    t_key          r_mem [DEPTH];
    t_key          r_rdata;
    logic [CW-1:0] rd_addr;
    logic          wr_en;
    logic [CW-1:0] wr_addr;
    t_key          wr_data;

    // result register
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic          r_o_entry_valid;
    t_key          r_o_entry_key;
    logic [3:0]    r_o_position;
    logic [4:0]    r_o_list_count;
    logic          r_o_last;

    t_step         step;
    logic          load;
    logic          emit;
    logic          tail;
    logic [CW-1:0] last_idx;

    dsl_step u_step (
        .i_op    (r_op),
        .i_key   (r_key),
        .i_rdata (r_rdata),
        .i_carry (r_carry),
        .i_flag  (r_flag),
        .o_step  (step)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign load     = !r_o_valid || !i_stall;
    assign emit     = load && (r_state == S_EMIT || r_state == S_SOLO);
    assign tail     = (r_i == r_count);
    assign last_idx = r_count - CW'(1);

    // read address: prefetch the next word while the current one is worked
    always_comb begin
        unique case (r_state)
            S_INS, S_DEL: rd_addr = r_i + CW'(1);
            S_EMIT:       rd_addr = load ? r_oidx + CW'(1) : r_oidx;
            default:      rd_addr = '0;
        endcase
    end

    // write port: ripple for inserts, shift toward the head for deletes
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_i;
        wr_data = step.wdata;
        unique case (r_state)
            S_INS: begin
                if (tail) begin
                    wr_en   = 1'b1;
                    wr_data = r_flag ? r_carry : r_key;
                end else begin
                    wr_en = step.we;
                end
            end
            S_DEL: begin
                wr_en   = step.we;
                wr_addr = step.back ? r_i - CW'(1) : r_i;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr[AW-1:0]] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            // load a new result word, or drop the current one once taken
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_op;
                        r_key  <= i_key;
                        r_flag <= 1'b0;
                        r_i    <= '0;
                        if (i_op == OP_INS) begin
                            if (r_count == CW'(DEPTH)) begin
                                r_solo_status <= ST_FULL;
                                r_state       <= S_SOLO;
                            end else begin
                                r_state <= S_INS;
                            end
                        end else begin
                            if (r_count == '0) begin
                                r_solo_status <= ST_MISS;
                                r_state       <= S_SOLO;
                            end else begin
                                r_state <= S_DEL;
                            end
                        end
                    end
                end
                S_INS: begin
                    if (tail) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_PREP;
                    end else begin
                        if (step.hit) begin
                            r_flag <= 1'b1;
                        end
                        if (step.hit || r_flag) begin
                            r_carry <= r_rdata;
                        end
                        r_i <= r_i + CW'(1);
                    end
                end
                S_DEL: begin
                    if (step.hit) begin
                        r_flag <= 1'b1;
                    end
                    if (r_i == last_idx) begin
                        if (r_flag || step.hit) begin
                            r_count <= last_idx;
                            if (last_idx == '0) begin
                                r_solo_status <= ST_OK;
                                r_state       <= S_SOLO;
                            end else begin
                                r_state <= S_PREP;
                            end
                        end else begin
                            r_solo_status <= ST_MISS;
                            r_state       <= S_SOLO;
                        end
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_PREP: begin
                    // store writes have landed; word 0 is read this cycle
                    r_oidx  <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        r_o_status      <= ST_OK;
                        r_o_entry_valid <= 1'b1;
                        r_o_entry_key   <= r_rdata;
                        r_o_position    <= 4'(r_oidx);
                        r_o_list_count  <= 5'(r_count);
                        r_o_last        <= (r_oidx == last_idx);
                        r_oidx          <= r_oidx + CW'(1);
                        if (r_oidx == last_idx) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_SOLO: begin
                    if (load) begin
                        r_o_status      <= r_solo_status;
                        r_o_entry_valid <= 1'b0;
                        r_o_entry_key   <= '0;
                        r_o_position    <= '0;
                        r_o_list_count  <= 5'(r_count);
                        r_o_last        <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_entry_valid = r_o_entry_valid;
    assign o_entry_key   = r_o_entry_key;
    assign o_position    = r_o_position;
    assign o_list_count  = r_o_list_count;
    assign o_last        = r_o_last;

endmodule

[hw/rtl/dsl_chk.sv]
// Port checker for the descending sorted list, bound to the top level.
// Depends on dsl_pkg and sees the top-level ports only.
module dsl_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [1:0]         o_status,
    input logic               o_entry_valid,
    input logic signed [31:0] o_entry_key,
    input logic [3:0]         o_position,
    input logic [4:0]         o_list_count,
    input logic               o_last
);
    import dsl_pkg::*;

    // hold a stalled result word
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_entry_key) && $stable(o_last)
            && $stable(o_status) && $stable(o_position))
        else $error("stalled result word changed");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("command accepted while still idle afterward");

    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_entry_valid |-> o_status == ST_OK)
        else $error("list word carries a failure status");

    a_solo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_valid |-> o_last && o_position == 4'd0 && o_entry_key == 32'sd0)
        else $error("status word not a lone final word");

endmodule

bind descending_sorted_list dsl_chk u_dsl_chk (.*);

[tb/dsl_checker.sv]
// Port checker for the descending sorted list: tracks the stored keys, predicts every result
// word and compares it with the result channel. Depends on dsl_pkg.
module dsl_checker #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  logic          i_cmd_stall,
    input  logic          i_op,
    input  dsl_pkg::t_key i_key,
    input  logic          i_res_valid,
    input  logic          i_res_stall,
    input  logic [1:0]    i_status,
    input  logic          i_entry_valid,
    input  dsl_pkg::t_key i_entry_key,
    input  logic [3:0]    i_position,
    input  logic [4:0]    i_list_count,
    input  logic          i_last,
    output int            o_fail_count,
    output int            o_pending
);
    import dsl_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       entry_valid;
        t_key       entry_key;
        logic [3:0] position;
        logic [4:0] list_count;
        logic       last;
    } t_list_word;

    t_key       sorted_keys [DEPTH];
    int         key_count = 0;
    t_list_word pending_words [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic push_word(input logic [1:0] status, input logic valid, input t_key key,
                             input int pos, input int cnt, input logic last);
        t_list_word w;
        w.status      = status;
        w.entry_valid = valid;
        w.entry_key   = key;
        w.position    = pos[3:0];
        w.list_count  = cnt[4:0];
        w.last        = last;
        pending_words.push_back(w);
    endtask

    // Apply one command to the key list and queue the words it produces
    task automatic apply_command(input logic op, input t_key key);
        int at;
        int hit;
        if (op == OP_INS) begin
            if (key_count >= DEPTH) begin
                push_word(ST_FULL, 1'b0, '0, 0, key_count, 1'b1);
                return;
            end
            at = key_count;
            for (int i = 0; i < key_count; i++) begin
                if (sorted_keys[i] <= key) begin
                    at = i;
                    break;
                end
            end
            for (int i = key_count; i > at; i--)
                sorted_keys[i] = sorted_keys[i-1];
            sorted_keys[at] = key;
            key_count++;
        end else begin
            hit = -1;
            for (int i = 0; i < key_count; i++) begin
                if (sorted_keys[i] == key) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) begin
                push_word(ST_MISS, 1'b0, '0, 0, key_count, 1'b1);
                return;
            end
            for (int i = hit; i + 1 < key_count; i++)
                sorted_keys[i] = sorted_keys[i+1];
            key_count--;
        end
        if (key_count == 0)
            push_word(ST_OK, 1'b0, '0, 0, 0, 1'b1);
        else
            for (int i = 0; i < key_count; i++)
                push_word(ST_OK, 1'b1, sorted_keys[i], i, key_count, i + 1 == key_count);
    endtask

    task automatic check_word();
        t_list_word w;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending (key %0h)",
                                      i_entry_key));
            return;
        end
        w = pending_words.pop_front();
        compare_field("status", i_status, w.status);
        compare_field("entry_valid", i_entry_valid, w.entry_valid);
        compare_field("entry_key", i_entry_key, w.entry_key);
        compare_field("position", i_position, w.position);
        compare_field("list_count", i_list_count, w.list_count);
        compare_field("last", i_last, w.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_count    = 0;
            o_fail_count = 0;
            pending_words.delete();
        end else begin
            if (i_res_valid && !i_res_stall)
                check_word();
            if (i_cmd_valid && !i_cmd_stall)
                apply_command(i_op, i_key);
        end
        o_pending = pending_words.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the descending sorted list: clock, reset, command stimulus and
// result-side stall pattern; prediction lives in dsl_checker. Depends on dsl_pkg.
module tb_top;
    import dsl_pkg::*;

    localparam int DEPTH        = 16;
    localparam int LONG_HOLD    = 300;      // cycles of the long result-side hold
    localparam int TAIL_CYCLES  = 2 * DEPTH + 20;
    localparam int LIMIT_CYCLES = 800_000;
    localparam int POOL_SIZE    = 12;
    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 25;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;

    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic       cmd_op = OP_INS;
    t_key       cmd_key = '0;

    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] res_status;
    logic       res_entry_valid;
    t_key       res_entry_key;
    logic [3:0] res_position;
    logic [4:0] res_list_count;
    logic       res_last;

    int         fail_count;
    int         pending;

    // Flip to ask the result side for one long hold
    logic       hold_toggle = 1'b0;
    bit         tx_quiet = 1'b0;
    t_key       key_pool [POOL_SIZE];

    always #5 clk = ~clk;

    descending_sorted_list #(.DEPTH(DEPTH)) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_valid       (cmd_valid),
        .o_stall       (cmd_stall),
        .i_op          (cmd_op),
        .i_key         (cmd_key),
        .o_valid       (res_valid),
        .i_stall       (res_stall),
        .o_status      (res_status),
        .o_entry_valid (res_entry_valid),
        .o_entry_key   (res_entry_key),
        .o_position    (res_position),
        .o_list_count  (res_list_count),
        .o_last        (res_last)
    );

    dsl_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd_stall   (cmd_stall),
        .i_op          (cmd_op),
        .i_key         (cmd_key),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_status      (res_status),
        .i_entry_valid (res_entry_valid),
        .i_entry_key   (res_entry_key),
        .i_position    (res_position),
        .i_list_count  (res_list_count),
        .i_last        (res_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly keys from a small pool so deletes hit and duplicates pile up;
    // the rest spans the full 32-bit range.
    function automatic t_key pick_key();
        if ($urandom_range(0, 9) < 2)
            return t_key'($urandom);
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Offer one command word after a random gap; return at the falling edge after
    // the edge that took it. Valid stays high into the next word when no gap follows.
    task automatic send_word(input logic op, input t_key key);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_op    <= op;
        cmd_key   <= key;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
    endtask

    // Drop valid and hold the sender until every predicted result word is out
    task automatic drain();
        cmd_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Result-side stall: random short and long holds, quiet stretches with no stall,
    // and a long hold whenever hold_toggle flips.
    initial begin : result_stall_gen
        int   stall_left;
        int   quiet_left;
        logic seen_toggle;
        stall_left  = 0;
        quiet_left  = 0;
        seen_toggle = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                stall_left  = LONG_HOLD;
                quiet_left  = 0;
            end
            if (stall_left == 0 && quiet_left == 0 && $urandom_range(0, 99) < 3)
                quiet_left = $urandom_range(50, 200);
            if (stall_left > 0) begin
                res_stall <= 1'b1;
                stall_left--;
            end else if (quiet_left > 0) begin
                res_stall <= 1'b0;
                quiet_left--;
            end else begin
                stall_left = pick_gap();
                if (stall_left > 0) begin
                    res_stall <= 1'b1;
                    stall_left--;
                end else begin
                    res_stall <= 1'b0;
                end
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        #(LIMIT_CYCLES * 10);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        bit insert_heavy;
        key_pool[0] = 32'sh7fff_ffff;
        key_pool[1] = 32'sh8000_0000;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int k = 4; k < POOL_SIZE; k++)
            key_pool[k] = t_key'($urandom_range(0, 200)) - 100;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: delete on an empty list misses; a delete that empties the
        // list gives the single empty-list word.
        send_word(OP_DEL, 7);
        send_word(OP_INS, 5);
        send_word(OP_DEL, 5);
        // Extremes, head and tail inserts, and a duplicate that lands ahead of its twin
        send_word(OP_INS, 32'sh7fff_ffff);
        send_word(OP_INS, 32'sh8000_0000);
        send_word(OP_INS, 0);
        send_word(OP_INS, -1);
        send_word(OP_INS, 0);
        // Delete first of two equal keys, delete at the tail, delete a missing key
        send_word(OP_DEL, 0);
        send_word(OP_DEL, 32'sh8000_0000);
        send_word(OP_DEL, 42);
        // Fill the table, then bounce one insert off the full table
        for (int k = 0; k < 13; k++)
            send_word(OP_INS, t_key'((k * 7919) % 2000 - 1000));
        send_word(OP_INS, 123);
        send_word(OP_DEL, 32'sh7fff_ffff);
        drain();

        // Random: alternate insert-heavy and delete-heavy phases so the list
        // swings between full and empty.
        for (int p = 0; p < PHASES; p++) begin
            insert_heavy = (p % 2 == 0);
            tx_quiet     = ($urandom_range(0, 3) == 0);
            if (p == 1) begin
                // Long hold on the result side while words keep coming, so the
                // block backs up and stalls its command side
                hold_toggle <= ~hold_toggle;
                tx_quiet = 1'b1;
            end
            if (p == 3)
                drain();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < (insert_heavy ? 75 : 25))
                    send_word(OP_INS, pick_key());
                else
                    send_word(OP_DEL, pick_key());
            end
        end

        // Wait out the last result words, then the block's tail latency
        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
